// ----- sv/kmdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Shared constants for the key matrix debounce and release detector.
// ----------------------------------------------------------------------------
package kmdr_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 5;
  localparam int unsigned ROWS_DEFAULT    = 3;

  localparam int unsigned COL_IN_W   = 3;
  localparam int unsigned ROWS_IN_W  = 3;
  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned CODE_W     = 6;
  localparam int unsigned TDATA_W    = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

  // Depth of the queue between the update front and the event back.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ----- sv/kmdr_queue.sv -----
// ----------------------------------------------------------------------------
// Release queue
// Small FIFO carrying the column and release mask of one sample.
// ----------------------------------------------------------------------------
module kmdr_queue #(
  parameter int unsigned WIDTH = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int unsigned DEPTH = kmdr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/kmdr_front.sv -----
// ----------------------------------------------------------------------------
// Debounce front
// Accepts column samples, updates the per-key debounce state of every row
// of the sampled column and queues the mask of keys released by the sample.
// ----------------------------------------------------------------------------
module kmdr_front #(
  parameter int unsigned COLUMNS = kmdr_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = kmdr_pkg::ROWS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [kmdr_pkg::LIMIT_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kmdr_pkg::COL_IN_W-1:0]     column_index,
  input  logic [kmdr_pkg::ROWS_IN_W-1:0]    pressed_rows,
  output logic                              push,
  output logic [kmdr_pkg::COL_IN_W+ROWS-1:0] push_data,
  input  logic                              queue_full
);

  localparam int unsigned COL_IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [kmdr_pkg::LIMIT_W-1:0] limit;
  logic [kmdr_pkg::LIMIT_W-1:0] counts [ROWS][COLUMNS];
  logic                         held   [ROWS][COLUMNS];

  logic            accept;
  logic            col_ok;
  logic [4:0]      col_ext;
  logic [COL_IW-1:0] col_idx;
  logic [ROWS-1:0] pressed;
  logic [ROWS-1:0] release_mask;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign col_ext  = {2'b00, column_index};
  assign col_ok   = (col_ext < 5'(COLUMNS));
  assign col_idx  = col_ext[COL_IW-1:0];

  // Rows beyond the width of the sample always read as unpressed.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      if (r < kmdr_pkg::ROWS_IN_W) begin
        pressed[r] = pressed_rows[r];
      end else begin
        pressed[r] = 1'b0;
      end
      release_mask[r] = !pressed[r] && held[r][col_idx];
    end
  end

  assign push      = accept && col_ok && (release_mask != '0);
  assign push_data = {release_mask, column_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= kmdr_pkg::LIMIT_RESET;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          counts[r][c] <= '0;
          held[r][c]   <= 1'b0;
        end
      end
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (accept && col_ok) begin
        for (int r = 0; r < ROWS; r++) begin
          if (pressed[r]) begin
            if (counts[r][col_idx] < limit) begin
              counts[r][col_idx] <= counts[r][col_idx] + 1'b1;
            end else begin
              held[r][col_idx] <= 1'b1;
            end
          end else begin
            counts[r][col_idx] <= '0;
            held[r][col_idx]   <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ----- sv/kmdr_back.sv -----
// ----------------------------------------------------------------------------
// Release event back
// Takes queued release masks and emits one key code per cycle while the output
// is not stalled, in ascending row order through an output register.
// ----------------------------------------------------------------------------
module kmdr_back #(
  parameter int unsigned ROWS = kmdr_pkg::ROWS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               queue_valid,
  input  logic [kmdr_pkg::COL_IN_W+ROWS-1:0] queue_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [kmdr_pkg::CODE_W-1:0]        key_code,
  output logic                               last_in_run
);

  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                           busy;
  logic [kmdr_pkg::COL_IN_W-1:0]  col;
  logic [ROWS-1:0]                mask;
  logic [ROWS-1:0]                mask_next;
  logic [ROW_W-1:0]               sel;
  logic                           out_free;
  logic [kmdr_pkg::CODE_W-1:0]    code_next;

  assign out_free = !out_valid || out_ready;
  assign pop      = !busy && queue_valid;

  // Lowest pending row.
  always_comb begin
    sel = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (mask[r]) begin
        sel = ROW_W'(r);
      end
    end
    mask_next      = mask;
    mask_next[sel] = 1'b0;
    code_next      = kmdr_pkg::CODE_W'((32'(sel) << 4) | 32'(col));
  end

  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      key_code    <= code_next;
      last_in_run <= (mask_next == '0);
    end
    if (pop) begin
      col <= queue_data[kmdr_pkg::COL_IN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (busy && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        mask <= queue_data[kmdr_pkg::COL_IN_W+ROWS-1:kmdr_pkg::COL_IN_W];
      end else if (busy && out_free) begin
        mask <= mask_next;
        if (mask_next == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/key_matrix_debounce_release.sv -----
// A sample's release events pass through the release queue, the event stage's
// mask register and the output register, then leave one per cycle while m_tready
// is high. Throughput: one sample per cycle while the two-entry release queue
// has room; the event stage takes a new sample only after its last event is out.
// Samples that release nothing never enter the queue.
// Reset clears all debounce counts and held flags and sets the limit to 5.
// ----------------------------------------------------------------------------
// Key matrix debounce and release detector
// Debounces column samples of a key matrix and emits release key codes.
// ----------------------------------------------------------------------------
module key_matrix_debounce_release #(
  parameter int unsigned COLUMNS = kmdr_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = kmdr_pkg::ROWS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kmdr_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [2:0] column_index, [5:3] pressed_rows, [7:6] zero
  input  logic [kmdr_pkg::TDATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [5:0] key_code, [7:6] zero
  output logic [kmdr_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);

  localparam int unsigned QW = kmdr_pkg::COL_IN_W + ROWS;

  logic          push;
  logic [QW-1:0] push_data;
  logic          queue_full;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          queue_valid;
  logic [kmdr_pkg::CODE_W-1:0] key_code;

  kmdr_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .column_index (s_tdata[2:0]),
    .pressed_rows (s_tdata[5:3]),
    .push         (push),
    .push_data    (push_data),
    .queue_full   (queue_full)
  );

  kmdr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (queue_valid)
  );

  kmdr_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_valid (queue_valid),
    .queue_data  (pop_data),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .key_code    (key_code),
    .last_in_run (m_tlast)
  );

  assign m_tdata = {2'b00, key_code};

endmodule
